>>> design/iprts_pkg.sv
// ============================================================================
// iprts_pkg: shared types and constants for the IPv4 range table search
// Holds the table entry layout, the item kind codes and the control states.
// ============================================================================
`default_nettype none

package iprts_pkg;

    // Fixed field widths of the item, result and configuration ports.
    localparam int unsigned ADDR_W   = 32;
    localparam int unsigned OFFSET_W = 24;
    localparam int unsigned SLOT_W   = 12;
    localparam int unsigned COUNT_W  = 13;

    // Item kind codes.
    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    // One table entry as stored in the range memory.
    typedef struct packed {
        logic [ADDR_W-1:0]   start_ip;
        logic [ADDR_W-1:0]   end_ip;
        logic [OFFSET_W-1:0] offset;
    } entry_t;

    // Control states of the search sequencer.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_FETCH
    } state_t;

endpackage

`default_nettype wire

>>> design/ip_range_table_search_top.sv
// ============================================================================
// ip_range_table_search_top: IPv4 range table with predecessor search
// Stores ranges sorted by start address in one memory and answers queries
// with the last entry whose start is not above the query address.
// ============================================================================
//
//  Channel | Direction | Handshake            | Payload
//  --------+-----------+----------------------+---------------------------------
//  in      | input     | in_valid / in_stall  | kind, entry_index, start_ip,
//          |           |                      | end_ip, entry_offset, query_ip
//  out     | output    | out_valid / out_stall| found_offset, found_index, hit
//  cfg     | input     | cfg_valid / cfg_ready| cfg_data (entry_count)
//
//  A load is written into the memory in the cycle of its transfer.
//  A query holds the input from its transfer until its result is registered:
//  the transfer, then probes of the single-port range memory, one per search
//  step, until the interval is empty, then the fetch state, which registers the
//  selected entry, read during the last probe, into the output.
//  A stalled result holds the next query in the fetch state.
//  A finished result waits in the output register while the next item is taken.
//  Reset initialises the control registers only (the entry count to one); the memory holds no reset value.
//
`default_nettype none

module ip_range_table_search_top #(
    parameter int unsigned TABLE_ENTRIES = 4096
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,

    // Configuration write channel.
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [iprts_pkg::COUNT_W-1:0]   cfg_data,

    // Input item channel.
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic                            kind,
    input  wire logic [iprts_pkg::SLOT_W-1:0]    entry_index,
    input  wire logic [iprts_pkg::ADDR_W-1:0]    start_ip,
    input  wire logic [iprts_pkg::ADDR_W-1:0]    end_ip,
    input  wire logic [iprts_pkg::OFFSET_W-1:0]  entry_offset,
    input  wire logic [iprts_pkg::ADDR_W-1:0]    query_ip,

    // Result channel.
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic [iprts_pkg::OFFSET_W-1:0]       found_offset,
    output logic [iprts_pkg::SLOT_W-1:0]         found_index,
    output logic                                 hit
);

    localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);
    localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam int unsigned SUM_W = CNT_W + 1;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    iprts_pkg::state_t                  state_reg, state_next;
    logic [iprts_pkg::COUNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]                   low_reg, low_next;
    logic [CNT_W-1:0]                   high_reg, high_next;
    logic [IDX_W-1:0]                   mid_reg, mid_next;
    logic [IDX_W-1:0]                   best_reg, best_next;
    logic                               found_reg, found_next;
    logic [iprts_pkg::ADDR_W-1:0]       query_reg, query_next;
    logic                               out_valid_reg, out_valid_next;
    logic [iprts_pkg::OFFSET_W-1:0]     out_offset_reg;
    logic [iprts_pkg::SLOT_W-1:0]       out_index_reg;
    logic                               out_hit_reg;

    // Memory and its ports.
    iprts_pkg::entry_t                  range_mem [TABLE_ENTRIES];
    iprts_pkg::entry_t                  rd_data_reg;
    iprts_pkg::entry_t                  wr_data;
    logic                               rd_en;
    logic [IDX_W-1:0]                   rd_addr;
    logic                               wr_en;
    logic [IDX_W-1:0]                   wr_addr;

    // Search datapath signals.
    logic                               in_xfer;
    logic                               load_out;
    logic [CNT_W-1:0]                   used_count;
    logic [IDX_W-1:0]                   first_mid;
    logic [CNT_W-1:0]                   mid_ext;
    logic [CNT_W-1:0]                   mid_plus_one;
    logic [SUM_W-1:0]                   sum_le;
    logic [SUM_W-1:0]                   sum_gt;
    logic [IDX_W-1:0]                   mid_le;
    logic [IDX_W-1:0]                   mid_gt;
    logic                               start_le;

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != iprts_pkg::ST_IDLE);
    assign in_xfer   = in_valid && !in_stall;

    // Entries in use: zero counts as one, and the count is clamped to the table.
    always_comb
    begin
        priority if (count_reg == '0)
        begin
            used_count = CNT_W'(1);
        end
        else if (32'(count_reg) > 32'(TABLE_ENTRIES))
        begin
            used_count = CNT_W'(TABLE_ENTRIES);
        end
        else
        begin
            used_count = CNT_W'(count_reg);
        end
    end

    // The first probe sits at half the count in use.
    assign first_mid = IDX_W'(used_count >> 1);

    // Both candidate next midpoints are formed in parallel with the compare.
    assign start_le     = (rd_data_reg.start_ip <= query_reg);
    assign mid_ext      = CNT_W'(mid_reg);
    assign mid_plus_one = mid_ext + CNT_W'(1);
    assign sum_le       = SUM_W'(mid_plus_one) + SUM_W'(high_reg);
    assign sum_gt       = SUM_W'(low_reg) + SUM_W'(mid_ext);
    assign mid_le       = sum_le[IDX_W:1];
    assign mid_gt       = sum_gt[IDX_W:1];

    // Result register loads once the selected entry is back and the slot is free.
    assign load_out = (state_reg == iprts_pkg::ST_FETCH) && (!out_valid_reg || !out_stall);

    // Next state, search bounds and memory control.
    always_comb
    begin
        state_next     = state_reg;
        low_next       = low_reg;
        high_next      = high_reg;
        mid_next       = mid_reg;
        best_next      = best_reg;
        found_next     = found_reg;
        query_next     = query_reg;
        rd_en          = 1'b0;
        rd_addr        = mid_reg;
        wr_en          = 1'b0;
        wr_addr        = IDX_W'(entry_index);
        wr_data        = '{start_ip: start_ip, end_ip: end_ip, offset: entry_offset};
        out_valid_next = out_valid_reg && out_stall;

        unique case (state_reg)
            iprts_pkg::ST_IDLE:
            begin
                if (in_xfer)
                begin
                    if (kind == iprts_pkg::KIND_QUERY)
                    begin
                        // First probe at the middle of the whole range in use.
                        low_next   = '0;
                        high_next  = used_count;
                        mid_next   = first_mid;
                        query_next = query_ip;
                        rd_en      = 1'b1;
                        rd_addr    = first_mid;
                        state_next = iprts_pkg::ST_SEARCH;
                    end
                    else if (32'(entry_index) < 32'(TABLE_ENTRIES))
                    begin
                        wr_en = 1'b1;
                    end
                end
            end

            iprts_pkg::ST_SEARCH:
            begin
                if (start_le)
                begin
                    low_next = mid_plus_one;
                    if (mid_plus_one < high_reg)
                    begin
                        mid_next = mid_le;
                        rd_en    = 1'b1;
                        rd_addr  = mid_le;
                    end
                    else
                    begin
                        best_next  = mid_reg;
                        found_next = 1'b1;
                        rd_en      = 1'b1;
                        rd_addr    = mid_reg;
                        state_next = iprts_pkg::ST_FETCH;
                    end
                end
                else
                begin
                    high_next = mid_ext;
                    if (low_reg < mid_ext)
                    begin
                        mid_next = mid_gt;
                        rd_en    = 1'b1;
                        rd_addr  = mid_gt;
                    end
                    else
                    begin
                        // The query is below the probed start: the answer lies under low.
                        if (low_reg == '0)
                        begin
                            best_next  = '0;
                            found_next = 1'b0;
                        end
                        else
                        begin
                            best_next  = IDX_W'(low_reg - CNT_W'(1));
                            found_next = 1'b1;
                        end
                        rd_en      = 1'b1;
                        rd_addr    = best_next;
                        state_next = iprts_pkg::ST_FETCH;
                    end
                end
            end

            iprts_pkg::ST_FETCH:
            begin
                if (load_out)
                begin
                    out_valid_next = 1'b1;
                    state_next     = iprts_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = iprts_pkg::ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= iprts_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Control registers and the entry count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= iprts_pkg::COUNT_W'(1);
            low_reg       <= '0;
            high_reg      <= '0;
            best_reg      <= '0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                count_reg <= cfg_data;
            end
            low_reg       <= low_next;
            high_reg      <= high_next;
            best_reg      <= best_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers of the search and the result.
    always_ff @(posedge clk)
    begin
        mid_reg   <= mid_next;
        query_reg <= query_next;
        if (load_out)
        begin
            out_offset_reg <= rd_data_reg.offset;
            out_index_reg  <= iprts_pkg::SLOT_W'(best_reg);
            out_hit_reg    <= found_reg && (rd_data_reg.end_ip >= query_reg);
        end
    end

    // Range memory: one port, written by loads, read by probes.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            range_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= range_mem[rd_addr];
        end
    end

    assign out_valid    = out_valid_reg;
    assign found_offset = out_offset_reg;
    assign found_index  = out_index_reg;
    assign hit          = out_hit_reg;

`ifndef SYNTHESIS
    // The search interval is never empty while a probe is outstanding.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == iprts_pkg::ST_SEARCH) |-> (low_reg < high_reg))
    else $error("search interval empty during a probe");

    // The probed index lies inside the current interval.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == iprts_pkg::ST_SEARCH) |->
            (mid_ext >= low_reg) && (mid_ext < high_reg))
    else $error("probe index outside the search interval");

    // A query with no predecessor selects entry zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == iprts_pkg::ST_FETCH) && !found_reg |-> (best_reg == '0))
    else $error("missing predecessor did not select entry zero");

    // An accepted query starts a search in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer && (kind == iprts_pkg::KIND_QUERY) |=> (state_reg == iprts_pkg::ST_SEARCH))
    else $error("accepted query did not start a search");

    // A waiting result is not replaced while the output is stalled.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_stall |=> out_valid_reg && $stable(out_index_reg))
    else $error("stalled result was overwritten");
`endif

endmodule

`default_nettype wire
